>>> rtl/q2e_pkg.sv
// shared types, constants and functions of the quaternion to euler unit
package q2e_pkg;

  localparam int MaxStages = 24;
  localparam int SqrtSteps = 27;
  localparam int AngleLimit = 25736;
  localparam logic signed [31:0] PiQ28 = 32'sd843314857;
  localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;
  localparam logic signed [35:0] OneQ28 = 36'sd268435456;

  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [31:0] z;
    logic               zero;
  } lane_t;

  typedef struct packed {
    logic [53:0] n;
    logic [53:0] res;
  } root_t;

  typedef struct packed {
    logic  vld;
    lane_t roll;
    lane_t yaw;
    root_t ra;
    root_t rb;
  } sq_stage_t;

  typedef struct packed {
    logic  vld;
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } cd_stage_t;

  function automatic logic signed [31:0] atan_q28(input int idx);
    logic signed [31:0] v;
    unique case (idx)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

  // q.28 angle to q3.13, round half away from zero, saturate
  function automatic logic signed [15:0] to_q13(input logic signed [33:0] v);
    logic [34:0] mag;
    logic [34:0] r;
    logic [15:0] m;
    mag = v[33] ? 35'(-36'(v)) : 35'(v);
    r = (mag + 35'(1 << 14)) >> 15;
    if (r > 35'(AngleLimit)) begin
      m = 16'(AngleLimit);
    end else begin
      m = r[15:0];
    end
    return v[33] ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> rtl/q2e_if.sv
// stream interfaces for quaternion input and angle output
interface q2e_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  modport source(output valid, output quat_w, output quat_x, output quat_y,
                 output quat_z, input ready);
  modport sink(input valid, input quat_w, input quat_x, input quat_y,
               input quat_z, output ready);
endinterface

interface q2e_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  modport source(output valid, output roll_angle, output pitch_angle,
                 output yaw_angle, input ready);
  modport sink(input valid, input roll_angle, input pitch_angle,
               input yaw_angle, output ready);
endinterface

>>> rtl/q2e_sqrt_cell.sv
// one step of the bit-serial square root for both pitch radicands
module q2e_sqrt_cell #(
  parameter int BIT_POS = 52
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  q2e_pkg::sq_stage_t  d_in,
  output q2e_pkg::sq_stage_t  d_out
);

  localparam logic [53:0] Bit = 54'(1) << BIT_POS;

  q2e_pkg::sq_stage_t stage_r;
  q2e_pkg::sq_stage_t stage_nxt;

  function automatic q2e_pkg::root_t step(input q2e_pkg::root_t r);
    q2e_pkg::root_t o;
    logic [53:0] trial;
    trial = r.res + Bit;
    if (r.n >= trial) begin
      o.n = r.n - trial;
      o.res = (r.res >> 1) + Bit;
    end else begin
      o.n = r.n;
      o.res = r.res >> 1;
    end
    return o;
  endfunction

  always_comb begin
    stage_nxt = d_in;
    stage_nxt.ra = step(d_in.ra);
    stage_nxt.rb = step(d_in.rb);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r.vld <= stage_nxt.vld;
    end
    if (en) begin
      stage_r.roll <= stage_nxt.roll;
      stage_r.yaw <= stage_nxt.yaw;
      stage_r.ra <= stage_nxt.ra;
      stage_r.rb <= stage_nxt.rb;
    end
  end

  assign d_out = stage_r;

endmodule

>>> rtl/q2e_cordic_cell.sv
// one vectoring cordic rotation for the roll, pitch and yaw lanes
module q2e_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  q2e_pkg::cd_stage_t  d_in,
  output q2e_pkg::cd_stage_t  d_out
);

  localparam logic signed [31:0] Atan = q2e_pkg::atan_q28(IDX);

  q2e_pkg::cd_stage_t stage_r;
  q2e_pkg::cd_stage_t stage_nxt;

  function automatic q2e_pkg::lane_t rot(input q2e_pkg::lane_t l);
    q2e_pkg::lane_t o;
    logic signed [35:0] xs;
    logic signed [35:0] ys;
    xs = l.x >>> IDX;
    ys = l.y >>> IDX;
    o.zero = l.zero;
    if (!l.y[35]) begin
      o.x = l.x + ys;
      o.y = l.y - xs;
      o.z = l.z + Atan;
    end else begin
      o.x = l.x - ys;
      o.y = l.y + xs;
      o.z = l.z - Atan;
    end
    return o;
  endfunction

  always_comb begin
    stage_nxt.vld = d_in.vld;
    stage_nxt.roll = rot(d_in.roll);
    stage_nxt.pitch = rot(d_in.pitch);
    stage_nxt.yaw = rot(d_in.yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.vld <= 1'b0;
    end else if (en) begin
      stage_r.vld <= stage_nxt.vld;
    end
    if (en) begin
      stage_r.roll <= stage_nxt.roll;
      stage_r.pitch <= stage_nxt.pitch;
      stage_r.yaw <= stage_nxt.yaw;
    end
  end

  assign d_out = stage_r;

endmodule

>>> rtl/quaternion_to_euler_unit.sv
// top level: quaternion to zyx euler angles, fully pipelined
// stages: two front stages, 27 square root cells, one prerotation stage,
// CORDIC_STAGES cordic cells (capped at 24) and the output register
// throughput: one transfer per cycle; the whole pipeline holds while out is stalled
// reset clears only the valid bits, payload registers are not reset
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  q2e_in_if.sink     in_ch,
  q2e_out_if.source  out_ch
);

  localparam int NumStages =
    (CORDIC_STAGES > q2e_pkg::MaxStages) ? q2e_pkg::MaxStages : CORDIC_STAGES;

  logic en;

  logic               a_vld_r;
  logic signed [31:0] pwx_r, pyz_r, pxx_r, pyy_r, pzz_r, pwz_r, pxy_r, pwy_r, pxz_r;

  q2e_pkg::sq_stage_t sq_pipe [0:q2e_pkg::SqrtSteps];
  q2e_pkg::sq_stage_t b_nxt;
  q2e_pkg::sq_stage_t b_r;

  q2e_pkg::cd_stage_t cd_pipe [0:NumStages];
  q2e_pkg::cd_stage_t pre_nxt;
  q2e_pkg::cd_stage_t pre_r;

  logic               out_vld_r;
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic signed [15:0] roll_nxt, pitch_nxt, yaw_nxt;

  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
    end
    if (en) begin
      pwx_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_x);
      pyz_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_z);
      pxx_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_x);
      pyy_r <= 32'(in_ch.quat_y) * 32'(in_ch.quat_y);
      pzz_r <= 32'(in_ch.quat_z) * 32'(in_ch.quat_z);
      pwz_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_z);
      pxy_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_y);
      pwy_r <= 32'(in_ch.quat_w) * 32'(in_ch.quat_y);
      pxz_r <= 32'(in_ch.quat_x) * 32'(in_ch.quat_z);
    end
  end

  // operands and radicands
  always_comb begin
    logic signed [35:0] t;
    logic signed [35:0] ra;
    logic signed [35:0] rb;
    b_nxt.vld = a_vld_r;
    b_nxt.roll.x = q2e_pkg::OneQ28 - ((36'(pxx_r) + 36'(pyy_r)) <<< 1);
    b_nxt.roll.y = (36'(pwx_r) + 36'(pyz_r)) <<< 1;
    b_nxt.roll.z = '0;
    b_nxt.roll.zero = 1'b0;
    b_nxt.yaw.x = q2e_pkg::OneQ28 - ((36'(pyy_r) + 36'(pzz_r)) <<< 1);
    b_nxt.yaw.y = (36'(pwz_r) + 36'(pxy_r)) <<< 1;
    b_nxt.yaw.z = '0;
    b_nxt.yaw.zero = 1'b0;
    t = (36'(pwy_r) - 36'(pxz_r)) <<< 1;
    ra = q2e_pkg::OneQ28 + t;
    rb = q2e_pkg::OneQ28 - t;
    if (ra[35]) ra = '0;
    if (rb[35]) rb = '0;
    b_nxt.ra.n = {1'b0, ra[32:0], 20'd0};
    b_nxt.ra.res = '0;
    b_nxt.rb.n = {1'b0, rb[32:0], 20'd0};
    b_nxt.rb.res = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r.vld <= 1'b0;
    end else if (en) begin
      b_r.vld <= b_nxt.vld;
    end
    if (en) begin
      b_r.roll <= b_nxt.roll;
      b_r.yaw <= b_nxt.yaw;
      b_r.ra <= b_nxt.ra;
      b_r.rb <= b_nxt.rb;
    end
  end

  assign sq_pipe[0] = b_r;

  for (genvar k = 0; k < q2e_pkg::SqrtSteps; k++) begin : g_sqrt
    q2e_sqrt_cell #(
      .BIT_POS(52 - 2 * k)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .d_in(sq_pipe[k]),
      .d_out(sq_pipe[k + 1])
    );
  end

  // prerotation by pi and zero detect
  function automatic q2e_pkg::lane_t prerot(input q2e_pkg::lane_t l);
    q2e_pkg::lane_t o;
    o.zero = (l.x == '0) && (l.y == '0);
    if (l.x[35]) begin
      o.z = l.y[35] ? -q2e_pkg::PiQ28 : q2e_pkg::PiQ28;
      o.x = -l.x;
      o.y = -l.y;
    end else begin
      o.z = '0;
      o.x = l.x;
      o.y = l.y;
    end
    return o;
  endfunction

  always_comb begin
    q2e_pkg::lane_t p;
    p.x = 36'(sq_pipe[q2e_pkg::SqrtSteps].rb.res[26:0]);
    p.y = 36'(sq_pipe[q2e_pkg::SqrtSteps].ra.res[26:0]);
    p.z = '0;
    p.zero = 1'b0;
    pre_nxt.vld = sq_pipe[q2e_pkg::SqrtSteps].vld;
    pre_nxt.roll = prerot(sq_pipe[q2e_pkg::SqrtSteps].roll);
    pre_nxt.pitch = prerot(p);
    pre_nxt.yaw = prerot(sq_pipe[q2e_pkg::SqrtSteps].yaw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_r.vld <= 1'b0;
    end else if (en) begin
      pre_r.vld <= pre_nxt.vld;
    end
    if (en) begin
      pre_r.roll <= pre_nxt.roll;
      pre_r.pitch <= pre_nxt.pitch;
      pre_r.yaw <= pre_nxt.yaw;
    end
  end

  assign cd_pipe[0] = pre_r;

  for (genvar k = 0; k < NumStages; k++) begin : g_cordic
    q2e_cordic_cell #(
      .IDX(k)
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .en(en),
      .d_in(cd_pipe[k]),
      .d_out(cd_pipe[k + 1])
    );
  end

  // rounding and saturation
  always_comb begin
    logic signed [31:0] zr;
    logic signed [31:0] zp;
    logic signed [31:0] zy;
    zr = cd_pipe[NumStages].roll.zero ? '0 : cd_pipe[NumStages].roll.z;
    zp = cd_pipe[NumStages].pitch.zero ? '0 : cd_pipe[NumStages].pitch.z;
    zy = cd_pipe[NumStages].yaw.zero ? '0 : cd_pipe[NumStages].yaw.z;
    roll_nxt = q2e_pkg::to_q13(34'(zr));
    pitch_nxt = q2e_pkg::to_q13((34'(zp) <<< 1) - 34'(q2e_pkg::HalfPiQ28));
    yaw_nxt = q2e_pkg::to_q13(34'(zy));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= cd_pipe[NumStages].vld;
    end
    if (en) begin
      roll_r <= roll_nxt;
      pitch_r <= pitch_nxt;
      yaw_r <= yaw_nxt;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.roll_angle = roll_r;
  assign out_ch.pitch_angle = pitch_r;
  assign out_ch.yaw_angle = yaw_r;

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> a_vld_r)
    else $error("transfer did not enter the product stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!en && pre_r.vld) |=> pre_r.vld)
    else $error("stalled pipeline lost an item");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (roll_r <= 16'sd25736 && roll_r >= -16'sd25736 &&
                      yaw_r <= 16'sd25736 && yaw_r >= -16'sd25736))
    else $error("roll or yaw out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pitch_r <= 16'sd25736 && pitch_r >= -16'sd25736))
    else $error("pitch out of range");

endmodule

>>> tb/q2e_tb_if.sv
// testbench item types for quaternion inputs and angle results
package q2e_tb_types;
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
  } angles_t;
  typedef struct packed {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;
endpackage

>>> tb/testbench.sv
// testbench for quaternion_to_euler_unit: random and directed quaternions checked against a predictor
module testbench;

  localparam int Stages = 16;
  localparam int Latency = 31 + Stages;
  localparam longint CycleLimit = 2000000;
  localparam longint HoldStart = 300;
  localparam int HoldLength = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #10 clk = ~clk;

  q2e_in_if in_ch ();
  q2e_out_if out_ch ();

  quaternion_to_euler_unit #(.CORDIC_STAGES(Stages)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  q2e_tb_types::quat_t pending_quats[$];
  q2e_tb_types::angles_t expected_angles[$];
  int error_count = 0;
  longint cycle_count = 0;
  int hold_cycles = 0;

  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint int_root(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint yv, longint xv);
    longint zacc, xs, ys;
    longint tab[24];
    tab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
            2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
            4096, 2048, 1024, 512, 256, 128, 64, 32};
    zacc = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      zacc = (yv >= 0) ? 64'sd843314857 : -64'sd843314857;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < ((Stages > 24) ? 24 : Stages); i++) begin
      xs = floor_shift(xv, i);
      ys = floor_shift(yv, i);
      if (yv >= 0) begin
        xv = xv + ys;
        yv = yv - xs;
        zacc = zacc + tab[i];
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        zacc = zacc - tab[i];
      end
    end
    return zacc;
  endfunction

  function automatic logic signed [15:0] angle_q13(longint v);
    longint r;
    if (v >= 0) r = (v + (64'sd1 << 14)) >>> 15;
    else r = -(((-v) + (64'sd1 << 14)) >>> 15);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return r[15:0];
  endfunction

  function automatic q2e_tb_types::angles_t predict_angles(q2e_tb_types::quat_t q);
    longint w, x, y, z, s, c, t, a, b, sa, sb;
    q2e_tb_types::angles_t e;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    s = 2 * (w * x + y * z);
    c = 64'sd268435456 - 2 * (x * x + y * y);
    e.roll = angle_q13(vector_angle(s, c));
    t = 2 * (w * y - x * z);
    a = 64'sd268435456 + t;
    b = 64'sd268435456 - t;
    if (a < 0) a = 0;
    if (b < 0) b = 0;
    sa = int_root(longint'(a) << 20);
    sb = int_root(longint'(b) << 20);
    e.pitch = angle_q13(2 * vector_angle(sa, sb) - 64'sd421657428);
    s = 2 * (w * z + x * y);
    c = 64'sd268435456 - 2 * (y * y + z * z);
    e.yaw = angle_q13(vector_angle(s, c));
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [15:0] rand_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
    return 16'($urandom);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      q2e_tb_types::quat_t q;
      if (in_ch.valid) begin
        q.w = in_ch.quat_w;
        q.x = in_ch.quat_x;
        q.y = in_ch.quat_y;
        q.z = in_ch.quat_z;
        expected_angles.push_back(predict_angles(q));
      end
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        q = pending_quats.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.quat_w <= q.w;
        in_ch.quat_x <= q.x;
        in_ch.quat_y <= q.y;
        in_ch.quat_z <= q.z;
        send_gap <= gap_length();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cycles <= 0;
    end else if (cycle_count == HoldStart) begin
      hold_cycles <= HoldLength;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end
  end

  // receiver stall and monitor
  int recv_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected transfer", 1, 0);
        end else begin
          q2e_tb_types::angles_t e;
          e = expected_angles.pop_front();
          if (out_ch.roll_angle !== e.roll) report_mismatch("roll", out_ch.roll_angle, e.roll);
          if (out_ch.pitch_angle !== e.pitch)
            report_mismatch("pitch", out_ch.pitch_angle, e.pitch);
          if (out_ch.yaw_angle !== e.yaw) report_mismatch("yaw", out_ch.yaw_angle, e.yaw);
        end
      end
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        recv_gap <= gap_length();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.quat_w = '0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    out_ch.ready = 1'b0;
    pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
    pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
    pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0});
    pending_quats.push_back('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0});
    pending_quats.push_back('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192});
    pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384});
    pending_quats.push_back('{16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384});
    pending_quats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    pending_quats.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000});
    pending_quats.push_back('{16'sh0, 16'sh7fff, 16'sh8000, 16'shffff});
    pending_quats.push_back('{16'shffff, 16'shffff, 16'shffff, 16'shffff});
    pending_quats.push_back('{16'sd0, -16'sd16384, 16'sd0, 16'sd0});
    for (int i = 0; i < 1800; i++)
      pending_quats.push_back('{rand_comp(), rand_comp(), rand_comp(), rand_comp()});
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_quats.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (error_count == 0 && expected_angles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
